FILE: rtl/tba_pkg.sv
// ----------------------------------------------------------------------------
// tba_pkg
// Shared types, codes and helpers of the two-bank slot tag allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package tba_pkg;

    localparam int MODE_W    = 3;
    localparam int TAG_W     = 11;
    localparam int SLOT_W    = 5;
    localparam int STATUS_W  = 2;
    localparam int MAX_SLOTS = 32;

    // Request modes
    localparam logic [MODE_W-1:0] MODE_ALLOC   = 3'd0;
    localparam logic [MODE_W-1:0] MODE_FREE    = 3'd1;
    localparam logic [MODE_W-1:0] MODE_LOCALS  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_RESERVE = 3'd3;
    localparam logic [MODE_W-1:0] MODE_RELEASE = 3'd4;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NO_FREE   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_RSVD  = 2'd3;

    // Fixed slot of each bank
    localparam logic [SLOT_W-1:0] FIXED_INT_SLOT   = 5'd0;
    localparam logic [SLOT_W-1:0] FIXED_FLOAT_SLOT = 5'd5;

    typedef struct packed {
        logic load;   // capture the accepted request
        logic exec;   // run the request and load the result register
    } tba_cmd_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [SLOT_W-1:0]   slot;
        logic                moved;
        logic [SLOT_W-1:0]   moved_to;
    } tba_rsp_t;

    // Lowest set bit: {found, index}
    function automatic logic [SLOT_W:0] first_set(input logic [MAX_SLOTS-1:0] v);
        logic [SLOT_W:0] r;
        r = '0;
        for (int i = MAX_SLOTS - 1; i >= 0; i--) begin
            if (v[i]) begin
                r = {1'b1, SLOT_W'(i)};
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/tba_if.sv
// ----------------------------------------------------------------------------
// tba_if
// Request and result channels of the slot tag allocator (valid/ready).
// ----------------------------------------------------------------------------
`default_nettype none

interface tba_req_if
    import tba_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [MODE_W-1:0] mode;
    logic              bank;
    logic [TAG_W-1:0]  tag;

    modport source (output valid, output mode, output bank, output tag, input ready);
    modport sink   (input valid, input mode, input bank, input tag, output ready);
endinterface

interface tba_rsp_if
    import tba_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot;
    logic                moved;
    logic [SLOT_W-1:0]   moved_to;

    modport source (output valid, output status, output slot, output moved,
                    output moved_to, input ready);
    modport sink   (input valid, input status, input slot, input moved,
                    input moved_to, output ready);
endinterface

`default_nettype wire

FILE: rtl/tba_ctrl.sv
// ----------------------------------------------------------------------------
// tba_ctrl
// Request sequencer: takes one request, runs it once the result register
// is free, and tracks the result valid flag.
// ----------------------------------------------------------------------------
`default_nettype none

module tba_ctrl
    import tba_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    output logic          in_ready,
    output logic          out_valid,
    input  wire logic     out_ready,
    output tba_cmd_t      cmd
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    logic state_reg;
    logic state_next;
    logic out_valid_reg;
    logic out_valid_next;

    always_comb
    begin
        in_ready = (state_reg == S_IDLE);
        cmd.load = in_valid && in_ready;
        cmd.exec = (state_reg == S_EXEC) && (!out_valid_reg || out_ready);

        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (cmd.load)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                // hold until the previous result leaves the output register
                if (cmd.exec)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (cmd.exec)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

FILE: rtl/tba_dpath.sv
// ----------------------------------------------------------------------------
// tba_dpath
// Slot tables of both banks, request register, free/match search and
// result register.
// ----------------------------------------------------------------------------
`default_nettype none

module tba_dpath
    import tba_pkg::*;
#(
    parameter int INT_SLOTS   = 16,
    parameter int FLOAT_SLOTS = 16,
    parameter int TEMP_LIMIT  = 1024
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire tba_cmd_t          cmd,
    input  wire logic [MODE_W-1:0] mode,
    input  wire logic              bank,
    input  wire logic [TAG_W-1:0]  tag,
    output tba_rsp_t               rsp
);

    localparam logic [TAG_W-1:0] LOCAL_TAG    = TAG_W'(TEMP_LIMIT);
    localparam logic [TAG_W-1:0] INT_MARKER   = TAG_W'(TEMP_LIMIT + 1);
    localparam logic [TAG_W-1:0] FLOAT_MARKER = TAG_W'(TEMP_LIMIT + 2);

    localparam int INT_FIX = int'(FIXED_INT_SLOT);
    localparam int FLT_FIX = int'(FIXED_FLOAT_SLOT);

    logic [MODE_W-1:0] mode_reg;
    logic              bank_reg;
    logic [TAG_W-1:0]  tag_reg;

    logic             int_used_reg   [INT_SLOTS];
    logic [TAG_W-1:0] int_owner_reg  [INT_SLOTS];
    logic             flt_used_reg   [FLOAT_SLOTS];
    logic [TAG_W-1:0] flt_owner_reg  [FLOAT_SLOTS];

    tba_rsp_t rsp_reg;
    tba_rsp_t rsp_next;

    logic [MAX_SLOTS-1:0] int_used_v, int_match_v, flt_used_v, flt_match_v;
    logic [MAX_SLOTS-1:0] sel_used_v, sel_match_v;
    logic [SLOT_W:0]      free_hit, match_hit;
    logic                 free_found, match_found;
    logic [SLOT_W-1:0]    free_idx, match_idx;

    logic [SLOT_W-1:0]    fixed_idx;
    logic                 fixed_used;
    logic [TAG_W-1:0]     fixed_owner;
    logic [TAG_W-1:0]     marker;

    // up to two table writes per request, plus the local sweep
    logic                 w0_en, w0_used, w1_en, clr_locals;
    logic [SLOT_W-1:0]    w0_idx, w1_idx;
    logic [TAG_W-1:0]     w0_owner, w1_owner;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mode_reg <= mode;
            bank_reg <= bank;
            tag_reg  <= tag;
        end
    end

    // Pad unused slot positions as used and never matching
    for (genvar i = 0; i < MAX_SLOTS; i++)
    begin : g_vec
        if (i < INT_SLOTS)
        begin : g_int
            assign int_used_v[i]  = int_used_reg[i];
            assign int_match_v[i] = int_used_reg[i] && (int_owner_reg[i] == tag_reg);
        end
        else
        begin : g_int_pad
            assign int_used_v[i]  = 1'b1;
            assign int_match_v[i] = 1'b0;
        end
        if (i < FLOAT_SLOTS)
        begin : g_flt
            assign flt_used_v[i]  = flt_used_reg[i];
            assign flt_match_v[i] = flt_used_reg[i] && (flt_owner_reg[i] == tag_reg);
        end
        else
        begin : g_flt_pad
            assign flt_used_v[i]  = 1'b1;
            assign flt_match_v[i] = 1'b0;
        end
    end

    always_comb
    begin
        sel_used_v  = bank_reg ? flt_used_v  : int_used_v;
        sel_match_v = bank_reg ? flt_match_v : int_match_v;
        free_hit    = first_set(~sel_used_v);
        match_hit   = first_set(sel_match_v);
        free_found  = free_hit[SLOT_W];
        free_idx    = free_hit[SLOT_W-1:0];
        match_found = match_hit[SLOT_W];
        match_idx   = match_hit[SLOT_W-1:0];

        fixed_idx   = bank_reg ? FIXED_FLOAT_SLOT : FIXED_INT_SLOT;
        fixed_used  = bank_reg ? flt_used_reg[FLT_FIX]
                               : int_used_reg[INT_FIX];
        fixed_owner = bank_reg ? flt_owner_reg[FLT_FIX]
                               : int_owner_reg[INT_FIX];
        marker      = bank_reg ? FLOAT_MARKER : INT_MARKER;

        w0_en      = 1'b0;
        w0_idx     = free_idx;
        w0_used    = 1'b1;
        w0_owner   = tag_reg;
        w1_en      = 1'b0;
        w1_idx     = free_idx;
        w1_owner   = fixed_owner;
        clr_locals = 1'b0;
        rsp_next   = '0;

        case (mode_reg)
            MODE_ALLOC:
            begin
                if (free_found)
                begin
                    w0_en         = 1'b1;
                    rsp_next.slot = free_idx;
                end
                else
                begin
                    rsp_next.status = ST_NO_FREE;
                end
            end
            MODE_FREE:
            begin
                if (match_found)
                begin
                    w0_en         = 1'b1;
                    w0_idx        = match_idx;
                    w0_used       = 1'b0;
                    w0_owner      = '0;
                    rsp_next.slot = match_idx;
                end
                else
                begin
                    rsp_next.status = ST_NOT_FOUND;
                end
            end
            MODE_LOCALS:
            begin
                clr_locals = 1'b1;
            end
            MODE_RESERVE:
            begin
                if (fixed_used && !free_found)
                begin
                    rsp_next.status = ST_NO_FREE;
                end
                else
                begin
                    // relocate the current owner before taking the slot
                    if (fixed_used)
                    begin
                        w1_en             = 1'b1;
                        rsp_next.moved    = 1'b1;
                        rsp_next.moved_to = free_idx;
                    end
                    w0_en         = 1'b1;
                    w0_idx        = fixed_idx;
                    w0_owner      = marker;
                    rsp_next.slot = fixed_idx;
                end
            end
            MODE_RELEASE:
            begin
                if (fixed_used && (fixed_owner == marker))
                begin
                    w0_en         = 1'b1;
                    w0_idx        = fixed_idx;
                    w0_used       = 1'b0;
                    w0_owner      = '0;
                    rsp_next.slot = fixed_idx;
                end
                else
                begin
                    rsp_next.status = ST_NOT_RSVD;
                end
            end
            default:
            begin
                rsp_next = '0;
            end
        endcase
    end

    for (genvar i = 0; i < INT_SLOTS; i++)
    begin : g_int_entry
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                int_used_reg[i] <= 1'b0;
            end
            else if (cmd.exec)
            begin
                if (clr_locals && int_used_reg[i] && (int_owner_reg[i] == LOCAL_TAG))
                begin
                    int_used_reg[i] <= 1'b0;
                end
                if (w0_en && !bank_reg && (w0_idx == SLOT_W'(i)))
                begin
                    int_used_reg[i] <= w0_used;
                end
                if (w1_en && !bank_reg && (w1_idx == SLOT_W'(i)))
                begin
                    int_used_reg[i] <= 1'b1;
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (cmd.exec && w0_en && !bank_reg && (w0_idx == SLOT_W'(i)))
            begin
                int_owner_reg[i] <= w0_owner;
            end
            else if (cmd.exec && w1_en && !bank_reg && (w1_idx == SLOT_W'(i)))
            begin
                int_owner_reg[i] <= w1_owner;
            end
        end
    end

    for (genvar i = 0; i < FLOAT_SLOTS; i++)
    begin : g_flt_entry
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                flt_used_reg[i] <= 1'b0;
            end
            else if (cmd.exec)
            begin
                if (clr_locals && flt_used_reg[i] && (flt_owner_reg[i] == LOCAL_TAG))
                begin
                    flt_used_reg[i] <= 1'b0;
                end
                if (w0_en && bank_reg && (w0_idx == SLOT_W'(i)))
                begin
                    flt_used_reg[i] <= w0_used;
                end
                if (w1_en && bank_reg && (w1_idx == SLOT_W'(i)))
                begin
                    flt_used_reg[i] <= 1'b1;
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (cmd.exec && w0_en && bank_reg && (w0_idx == SLOT_W'(i)))
            begin
                flt_owner_reg[i] <= w0_owner;
            end
            else if (cmd.exec && w1_en && bank_reg && (w1_idx == SLOT_W'(i)))
            begin
                flt_owner_reg[i] <= w1_owner;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp = rsp_reg;

endmodule

`default_nettype wire

FILE: rtl/two_bank_register_tag_allocator_core.sv
// ----------------------------------------------------------------------------
// two_bank_register_tag_allocator_core
// Integer and float slot tables with owner tags: allocate lowest free slot,
// free by tag, sweep locals, reserve and release each bank's fixed slot.
//
//  Channel | Dir | Payload                          | Transaction
//  --------+-----+----------------------------------+-------------------------
//  req     | in  | mode, bank, tag                  | valid & ready
//  rsp     | out | status, slot, moved, moved_to    | valid & ready, one per req
//
//  A request is first captured in the request register; then the tables are
//  searched and written together with the result register.
//  The next request is taken while the last result still waits in its
//  register; execution holds only when that register is still full.
//  Reset frees every slot of both banks at once; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module two_bank_register_tag_allocator_core
    import tba_pkg::*;
#(
    parameter int INT_SLOTS   = 16,
    parameter int FLOAT_SLOTS = 16,
    parameter int TEMP_LIMIT  = 1024
)
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    tba_req_if.sink    req,
    tba_rsp_if.source  rsp
);

    tba_cmd_t cmd;
    tba_rsp_t result;

    tba_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .cmd       (cmd)
    );

    tba_dpath #(
        .INT_SLOTS   (INT_SLOTS),
        .FLOAT_SLOTS (FLOAT_SLOTS),
        .TEMP_LIMIT  (TEMP_LIMIT)
    ) u_dpath (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .mode  (req.mode),
        .bank  (req.bank),
        .tag   (req.tag),
        .rsp   (result)
    );

    assign rsp.status   = result.status;
    assign rsp.slot     = result.slot;
    assign rsp.moved    = result.moved;
    assign rsp.moved_to = result.moved_to;

endmodule

`default_nettype wire

FILE: rtl/tba_checker.sv
// ----------------------------------------------------------------------------
// tba_checker
// Port-level checks of the slot tag allocator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module tba_checker
    import tba_pkg::*;
(
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                req_valid,
    input wire logic                req_ready,
    input wire logic                rsp_valid,
    input wire logic                rsp_ready,
    input wire logic [STATUS_W-1:0] rsp_status,
    input wire logic [SLOT_W-1:0]   rsp_slot,
    input wire logic                rsp_moved,
    input wire logic [SLOT_W-1:0]   rsp_moved_to
);

    // a stalled result stays offered
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("result dropped while stalled");

    // one request in flight at a time
    a_one_req: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request taken while another is in flight");

    // failed requests report no slot and no move
    a_err_clean: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_status != ST_OK) |->
            (rsp_slot == '0) && !rsp_moved && (rsp_moved_to == '0))
        else $error("error result carries slot data");

    // a move only happens on a successful reserve of a fixed slot
    a_move_ok: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_moved |->
            (rsp_status == ST_OK) &&
            ((rsp_slot == FIXED_INT_SLOT) || (rsp_slot == FIXED_FLOAT_SLOT)) &&
            (rsp_moved_to != rsp_slot))
        else $error("bad relocation report");

    a_no_move_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_moved |-> (rsp_moved_to == '0))
        else $error("move target set without a move");

endmodule

bind two_bank_register_tag_allocator_core tba_checker u_tba_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .req_valid    (req.valid),
    .req_ready    (req.ready),
    .rsp_valid    (rsp.valid),
    .rsp_ready    (rsp.ready),
    .rsp_status   (rsp.status),
    .rsp_slot     (rsp.slot),
    .rsp_moved    (rsp.moved),
    .rsp_moved_to (rsp.moved_to)
);

`default_nettype wire

FILE: tb/sv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the two-bank slot tag allocator. Requests go in on
// the request channel; a shadow copy of both slot tables predicts each result
// when its request is accepted, and every returned result is matched in order.
// Traffic is directed corner cases first, then random fill, drain and mixed
// sequences with random gaps and stalls on both channels.
// ----------------------------------------------------------------------------

module tb_top;
    import tba_pkg::*;

    localparam int NUM_SLOTS  = 16;
    localparam int TEMP_LIMIT = 1024;

    localparam logic [TAG_W-1:0] LOCAL_TAG  = TAG_W'(TEMP_LIMIT);
    localparam logic [TAG_W-1:0] INT_MARK   = TAG_W'(TEMP_LIMIT + 1);
    localparam logic [TAG_W-1:0] FLOAT_MARK = TAG_W'(TEMP_LIMIT + 2);

    localparam logic [MODE_W-1:0] MODE_SPARE_LO = 3'd5;
    localparam logic [MODE_W-1:0] MODE_SPARE_HI = 3'd7;

    localparam logic BANK_INT   = 1'b0;
    localparam logic BANK_FLOAT = 1'b1;

    logic clk;
    logic rst_n;

    tba_req_if req_ch ();
    tba_rsp_if rsp_ch ();

    two_bank_register_tag_allocator_core #(
        .INT_SLOTS   (NUM_SLOTS),
        .FLOAT_SLOTS (NUM_SLOTS),
        .TEMP_LIMIT  (TEMP_LIMIT)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // Shadow slot tables, indexed [bank][slot]
    logic             slot_busy  [2][NUM_SLOTS];
    logic [TAG_W-1:0] slot_owner [2][NUM_SLOTS];

    tba_rsp_t pending_results[$];
    tba_rsp_t want;

    int errors;
    int items_sent;
    int mode_count[8];
    int status_count[4];
    int move_count;

    bit gaps_on;
    int hold_cycles_req;
    int hold_left;
    int stall_left;

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial begin
        #20_000_000;
        $display("FAIL two_bank_register_tag_allocator_core");
        $finish;
    end

    // Mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        if (!gaps_on) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Compute the result of one request and update the shadow tables
    function automatic tba_rsp_t predict_alloc_result(logic [MODE_W-1:0] mode, logic bank,
                                                      logic [TAG_W-1:0] tag);
        tba_rsp_t r;
        int lf;
        int fx;
        logic [TAG_W-1:0] mark;
        r = '0;
        fx = bank ? int'(FIXED_FLOAT_SLOT) : int'(FIXED_INT_SLOT);
        mark = bank ? FLOAT_MARK : INT_MARK;
        lf = -1;
        for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
            if (!slot_busy[bank][i]) lf = i;
        end
        case (mode)
            MODE_ALLOC: begin
                if (lf < 0) begin
                    r.status = ST_NO_FREE;
                end else begin
                    slot_busy[bank][lf] = 1'b1;
                    slot_owner[bank][lf] = tag;
                    r.slot = SLOT_W'(lf);
                end
            end
            MODE_FREE: begin
                r.status = ST_NOT_FOUND;
                for (int i = 0; i < NUM_SLOTS; i++) begin
                    if (r.status == ST_NOT_FOUND && slot_busy[bank][i]
                        && slot_owner[bank][i] == tag) begin
                        slot_busy[bank][i] = 1'b0;
                        slot_owner[bank][i] = '0;
                        r.status = ST_OK;
                        r.slot = SLOT_W'(i);
                    end
                end
            end
            MODE_LOCALS: begin
                for (int b = 0; b < 2; b++) begin
                    for (int i = 0; i < NUM_SLOTS; i++) begin
                        if (slot_busy[b][i] && slot_owner[b][i] == LOCAL_TAG) begin
                            slot_busy[b][i] = 1'b0;
                            slot_owner[b][i] = '0;
                        end
                    end
                end
            end
            MODE_RESERVE: begin
                if (slot_busy[bank][fx]) begin
                    if (lf < 0) begin
                        r.status = ST_NO_FREE;
                    end else begin
                        // relocate the current owner before taking the fixed slot
                        slot_busy[bank][lf] = 1'b1;
                        slot_owner[bank][lf] = slot_owner[bank][fx];
                        r.moved = 1'b1;
                        r.moved_to = SLOT_W'(lf);
                    end
                end
                if (r.status == ST_OK) begin
                    slot_busy[bank][fx] = 1'b1;
                    slot_owner[bank][fx] = mark;
                    r.slot = SLOT_W'(fx);
                end
            end
            MODE_RELEASE: begin
                if (slot_busy[bank][fx] && slot_owner[bank][fx] == mark) begin
                    slot_busy[bank][fx] = 1'b0;
                    slot_owner[bank][fx] = '0;
                    r.slot = SLOT_W'(fx);
                end else begin
                    r.status = ST_NOT_RSVD;
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic int free_slots(logic bank);
        int n;
        n = 0;
        for (int i = 0; i < NUM_SLOTS; i++) begin
            if (!slot_busy[bank][i]) n++;
        end
        return n;
    endfunction

    function automatic logic [TAG_W-1:0] random_tag(logic bank);
        int r;
        r = $urandom_range(0, 99);
        if (r < 25) return LOCAL_TAG;
        if (r < 30) return bank ? FLOAT_MARK : INT_MARK;
        if (r < 35) return TAG_W'($urandom_range(0, 2047));
        if (r < 60) return TAG_W'($urandom_range(0, 7));
        return TAG_W'($urandom_range(0, TEMP_LIMIT - 1));
    endfunction

    // Tag of a random used slot, so that frees mostly hit
    function automatic logic [TAG_W-1:0] pick_owned_tag(logic bank);
        int idx[$];
        for (int i = 0; i < NUM_SLOTS; i++) begin
            if (slot_busy[bank][i]) idx.push_back(i);
        end
        if (idx.size() == 0) return random_tag(bank);
        return slot_owner[bank][idx[$urandom_range(0, idx.size() - 1)]];
    endfunction

    // Drive one request and hold it until the transaction completes
    task automatic send_request(input logic [MODE_W-1:0] mode, input logic bank,
                                input logic [TAG_W-1:0] tag);
        int gap;
        req_ch.valid <= 1'b1;
        req_ch.mode  <= mode;
        req_ch.bank  <= bank;
        req_ch.tag   <= tag;
        @(posedge clk);
        while (!req_ch.ready) @(posedge clk);
        pending_results.push_back(predict_alloc_result(mode, bank, tag));
        mode_count[mode]++;
        items_sent++;
        gap = pick_gap();
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic wait_for_results();
        req_ch.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
    endtask

    // Receiver: random stalls plus an occasional long hold-off
    initial begin
        rsp_ch.ready <= 1'b0;
        hold_left = 0;
        stall_left = 0;
        forever begin
            @(posedge clk);
            if (hold_cycles_req > 0) begin
                hold_left = hold_cycles_req;
                hold_cycles_req = 0;
            end
            if (hold_left > 0) begin
                rsp_ch.ready <= 1'b0;
                hold_left--;
            end else if (stall_left > 0) begin
                rsp_ch.ready <= 1'b0;
                stall_left--;
            end else begin
                rsp_ch.ready <= 1'b1;
                if ($urandom_range(0, 99) < 25) stall_left = pick_gap();
            end
        end
    end

    always @(posedge clk) begin
        if (rst_n && rsp_ch.valid && rsp_ch.ready) begin
            if (pending_results.size() == 0) begin
                $error("result with nothing outstanding: status %0d slot %0d",
                       rsp_ch.status, rsp_ch.slot);
                errors++;
            end else begin
                want = pending_results.pop_front();
                status_count[want.status]++;
                if (want.moved) move_count++;
                if (rsp_ch.status !== want.status) begin
                    $error("status: expected %0d, actual %0d", want.status, rsp_ch.status);
                    errors++;
                end
                if (rsp_ch.slot !== want.slot) begin
                    $error("slot: expected %0d, actual %0d", want.slot, rsp_ch.slot);
                    errors++;
                end
                if (rsp_ch.moved !== want.moved) begin
                    $error("moved: expected %0d, actual %0d", want.moved, rsp_ch.moved);
                    errors++;
                end
                if (rsp_ch.moved_to !== want.moved_to) begin
                    $error("moved_to: expected %0d, actual %0d",
                           want.moved_to, rsp_ch.moved_to);
                    errors++;
                end
            end
        end
    end

    // Fresh tables: nothing to free, nothing reserved
    task automatic test_reset_state();
        send_request(MODE_FREE, BANK_INT, '0);
        send_request(MODE_RELEASE, BANK_INT, '0);
        send_request(MODE_RELEASE, BANK_FLOAT, '0);
    endtask

    task automatic test_alloc_free();
        send_request(MODE_ALLOC, BANK_INT, '0);
        send_request(MODE_ALLOC, BANK_INT, '1);
        send_request(MODE_ALLOC, BANK_INT, LOCAL_TAG);
        send_request(MODE_ALLOC, BANK_FLOAT, LOCAL_TAG);
        send_request(MODE_ALLOC, BANK_FLOAT, TAG_W'(5));
        send_request(MODE_FREE, BANK_INT, '1);
        send_request(MODE_FREE, BANK_INT, '1);
        send_request(MODE_ALLOC, BANK_INT, TAG_W'(3));
        send_request(MODE_LOCALS, BANK_FLOAT, '0);
        send_request(MODE_SPARE_LO, BANK_INT, '1);
        send_request(MODE_SPARE_LO + 3'd1, BANK_FLOAT, LOCAL_TAG);
        send_request(MODE_SPARE_HI, BANK_FLOAT, '0);
    endtask

    task automatic test_fixed_slots();
        send_request(MODE_RESERVE, BANK_INT, '0);    // owner of slot 0 moves out
        send_request(MODE_RESERVE, BANK_INT, '0);    // marker itself is relocated
        send_request(MODE_FREE, BANK_INT, INT_MARK);
        send_request(MODE_RELEASE, BANK_INT, '0);
        send_request(MODE_RELEASE, BANK_INT, '0);
        send_request(MODE_RESERVE, BANK_FLOAT, '0);
        send_request(MODE_ALLOC, BANK_FLOAT, FLOAT_MARK);
        send_request(MODE_RELEASE, BANK_FLOAT, '0);
        send_request(MODE_FREE, BANK_FLOAT, FLOAT_MARK);
        send_request(MODE_RELEASE, BANK_FLOAT, '0);
    endtask

    task automatic run_fill_burst();
        logic b;
        b = 1'($urandom_range(0, 1));
        if ($urandom_range(0, 1)) send_request(MODE_RESERVE, b, '0);
        while (free_slots(b) > 0) send_request(MODE_ALLOC, b, random_tag(b));
        repeat ($urandom_range(1, 2)) send_request(MODE_ALLOC, b, random_tag(b));
        send_request(MODE_RESERVE, b, '0);
        send_request(MODE_RELEASE, b, '0);
        send_request(MODE_RESERVE, b, '0);
    endtask

    task automatic run_drain_burst();
        logic b;
        b = 1'($urandom_range(0, 1));
        if ($urandom_range(0, 1)) send_request(MODE_LOCALS, 1'($urandom_range(0, 1)), '0);
        repeat (NUM_SLOTS - free_slots(b)) send_request(MODE_FREE, b, pick_owned_tag(b));
        send_request(MODE_RELEASE, b, '0);
    endtask

    task automatic send_random_op();
        logic b;
        int r;
        b = 1'($urandom_range(0, 1));
        r = $urandom_range(0, 99);
        if (r < 38) send_request(MODE_ALLOC, b, random_tag(b));
        else if (r < 63) send_request(MODE_FREE, b, pick_owned_tag(b));
        else if (r < 68) send_request(MODE_FREE, b, random_tag(b));
        else if (r < 73) send_request(MODE_LOCALS, b, random_tag(b));
        else if (r < 85) send_request(MODE_RESERVE, b, random_tag(b));
        else if (r < 97) send_request(MODE_RELEASE, b, random_tag(b));
        else send_request(MODE_W'($urandom_range(MODE_SPARE_LO, MODE_SPARE_HI)), b,
                          TAG_W'($urandom_range(0, 2047)));
    endtask

    task automatic test_random_traffic(input int n_items);
        int target;
        int r;
        target = items_sent + n_items;
        while (items_sent < target) begin
            r = $urandom_range(0, 99);
            if (r < 15) begin
                run_fill_burst();
            end else if (r < 27) begin
                run_drain_burst();
            end else if (r < 30) begin
                wait_for_results();
                repeat ($urandom_range(1, 20)) @(posedge clk);
            end else begin
                repeat ($urandom_range(10, 30)) send_random_op();
            end
        end
    endtask

    // Receiver holds off while the sender keeps pushing, so the input stalls
    task automatic test_backpressure();
        gaps_on = 1'b0;
        hold_cycles_req = 200;
        repeat (12) send_random_op();
        gaps_on = 1'b1;
        wait_for_results();
    endtask

    task automatic test_drain_pause();
        repeat (8) send_random_op();
        wait_for_results();
        repeat (30) @(posedge clk);
        repeat (8) send_random_op();
    endtask

    initial begin
        req_ch.valid <= 1'b0;
        req_ch.mode  <= MODE_ALLOC;
        req_ch.bank  <= BANK_INT;
        req_ch.tag   <= '0;
        rst_n        <= 1'b0;
        errors = 0;
        items_sent = 0;
        move_count = 0;
        hold_cycles_req = 0;
        gaps_on = 1'b1;
        for (int b = 0; b < 2; b++) begin
            for (int i = 0; i < NUM_SLOTS; i++) begin
                slot_busy[b][i] = 1'b0;
                slot_owner[b][i] = '0;
            end
        end
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_state();
        test_alloc_free();
        test_fixed_slots();
        gaps_on = 1'b0;
        test_random_traffic(200);
        gaps_on = 1'b1;
        test_backpressure();
        test_drain_pause();
        test_random_traffic(1250);

        wait_for_results();
        repeat (10) @(posedge clk);
        $display({"Covered %0d requests: alloc %0d, free %0d, locals %0d, ",
                  "reserve %0d, release %0d, spare modes %0d"},
                 items_sent, mode_count[MODE_ALLOC], mode_count[MODE_FREE],
                 mode_count[MODE_LOCALS], mode_count[MODE_RESERVE], mode_count[MODE_RELEASE],
                 mode_count[5] + mode_count[6] + mode_count[7]);
        $display({"Results seen: ok %0d, no free %0d, not found %0d, ",
                  "not reserved %0d, owner moves %0d"},
                 status_count[ST_OK], status_count[ST_NO_FREE], status_count[ST_NOT_FOUND],
                 status_count[ST_NOT_RSVD], move_count);
        if (errors == 0) begin
            $display("PASS two_bank_register_tag_allocator_core");
        end else begin
            $display("FAIL two_bank_register_tag_allocator_core");
        end
        $finish;
    end

endmodule
